FILE: sv/nsc_pkg.sv
// Shared types and constants for the NMEA sentence checksum checker.
package nsc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    localparam logic [5:0] ERR_OFS_MISMATCH = 6'd2;
    localparam logic [5:0] ERR_OFS_OVERFLOW = 6'd3;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BODY = 2'd1,
        PH_SUM  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        V_NONE     = 2'd0,
        V_OK       = 2'd1,
        V_MISMATCH = 2'd2,
        V_OVERFLOW = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [31:0] error_word;
        logic [7:0]  received_sum;
        logic [7:0]  computed_sum;
        logic [6:0]  body_length;
        t_verdict    verdict;
    } t_result;

endpackage

FILE: sv/nsc_core.sv
// Sentence state, checksum accumulation and verdict: one byte a cycle while enabled.
module nsc_core #(
    parameter int MAX_LENGTH = 72
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [7:0]      i_byte,
    input  logic [4:0]      i_err_base,
    output nsc_pkg::t_result o_res
);

    nsc_pkg::t_phase r_phase, n_phase;
    logic [6:0]      r_len, n_len;
    logic [7:0]      r_xor, n_xor;
    logic [15:0]     r_last, n_last;
    logic [31:0]     r_sticky, n_sticky;

    nsc_pkg::t_verdict w_verdict;
    logic [6:0]        w_len_inc;
    logic [7:0]        w_received;
    logic [4:0]        w_hi, w_lo;
    logic [5:0]        w_pos_mis, w_pos_ovf;

    // Decodes one uppercase hex digit; bit 4 flags a valid digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= nsc_pkg::CH_ZERO && c <= nsc_pkg::CH_NINE) begin
            d = c - nsc_pkg::CH_ZERO;
            return {1'b1, d[3:0]};
        end else if (c >= nsc_pkg::CH_UPPER_A && c <= nsc_pkg::CH_UPPER_F) begin
            d = c - nsc_pkg::CH_UPPER_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

    assign w_len_inc = r_len + 7'd1;
    assign w_hi      = hex_nibble(r_last[15:8]);
    assign w_lo      = hex_nibble(r_last[7:0]);
    assign w_pos_mis = {1'b0, i_err_base} + nsc_pkg::ERR_OFS_MISMATCH;
    assign w_pos_ovf = {1'b0, i_err_base} + nsc_pkg::ERR_OFS_OVERFLOW;

    // Datapath and verdict for the byte in flight.
    always_comb begin
        n_len      = r_len;
        n_xor      = r_xor;
        n_last     = r_last;
        n_sticky   = r_sticky;
        w_verdict  = nsc_pkg::V_NONE;
        w_received = 8'h00;
        if (r_phase != nsc_pkg::PH_HUNT) begin
            n_len  = w_len_inc;
            n_last = {r_last[7:0], i_byte};
            if (r_phase == nsc_pkg::PH_BODY) begin
                if (i_byte != nsc_pkg::CH_STAR) begin
                    n_xor = r_xor ^ i_byte;
                end
            end else if (i_byte == nsc_pkg::CH_CR) begin
                w_received = {w_hi[3:0], w_lo[3:0]};
                if (w_hi[4] && w_lo[4] && w_received == r_xor) begin
                    w_verdict = nsc_pkg::V_OK;
                end else begin
                    w_verdict = nsc_pkg::V_MISMATCH;
                    if (!w_pos_mis[5]) begin
                        n_sticky = n_sticky | (32'd1 << w_pos_mis[4:0]);
                    end
                end
            end
            if (w_verdict == nsc_pkg::V_NONE && w_len_inc > 7'(MAX_LENGTH)) begin
                w_verdict = nsc_pkg::V_OVERFLOW;
                if (!w_pos_ovf[5]) begin
                    n_sticky = n_sticky | (32'd1 << w_pos_ovf[4:0]);
                end
            end
        end
        o_res.verdict      = w_verdict;
        o_res.body_length  = n_len;
        o_res.computed_sum = n_xor;
        o_res.received_sum = w_received;
        o_res.error_word   = n_sticky;
    end

    // Phase sequencing.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            nsc_pkg::PH_HUNT: begin
                if (i_byte == nsc_pkg::CH_DOLLAR) begin
                    n_phase = nsc_pkg::PH_BODY;
                end
            end
            nsc_pkg::PH_BODY: begin
                if (w_verdict != nsc_pkg::V_NONE) begin
                    n_phase = nsc_pkg::PH_HUNT;
                end else if (i_byte == nsc_pkg::CH_STAR) begin
                    n_phase = nsc_pkg::PH_SUM;
                end
            end
            nsc_pkg::PH_SUM: begin
                if (w_verdict != nsc_pkg::V_NONE) begin
                    n_phase = nsc_pkg::PH_HUNT;
                end
            end
            default: begin
                n_phase = nsc_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= nsc_pkg::PH_HUNT;
            r_len    <= 7'd0;
            r_xor    <= 8'h00;
            r_last   <= 16'h0000;
            r_sticky <= 32'h0000_0000;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_sticky <= n_sticky;
            if (w_verdict != nsc_pkg::V_NONE) begin
                r_len  <= 7'd0;
                r_xor  <= 8'h00;
                r_last <= 16'h0000;
            end else begin
                r_len  <= n_len;
                r_xor  <= n_xor;
                r_last <= n_last;
            end
        end
    end

    // While hunting, the sentence registers are always in their cleared state.
    a_hunt_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == nsc_pkg::PH_HUNT |-> (r_len == 7'd0 && r_xor == 8'h00 && r_last == 16'h0000))
        else $error("sentence state not cleared while hunting");

    // Error flags only accumulate between resets.
    a_sticky_keep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_sticky & $past(r_sticky)) == $past(r_sticky)))
        else $error("sticky error bit dropped");

    // An overlong sentence is always closed, so the stored count stays in range.
    a_len_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= 7'(MAX_LENGTH))
        else $error("stored sentence length beyond maximum");

endmodule

FILE: sv/nmea_sentence_checker.sv
// Top level of the NMEA 0183 sentence checksum checker with stream ports.
// Path: an accepted byte waits in the input register until the result register is free or
// draining, then its result is registered there and offered on the result stream.
// Throughput: one byte per cycle unless results stall; nsc_core updates per byte.
// Reset: i_rst_n is synchronous, active low; it empties both pipeline registers, returns the
// checker to hunting for a dollar sign and clears the error word and the error bit base.
module nmea_sentence_checker #(
    parameter int MAX_LENGTH = 72
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [1:0] verdict, [8:2] body_length, [16:9] computed_sum,
                                     // [24:17] received_sum, [56:25] error_word, rest zero
    // Error bit base register write.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    // The input register holds one request; the result register holds one result.
    // The checker advances whenever a request is waiting and the result register is free
    // or being drained in the same cycle, so both sides can move on every clock.
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    nsc_pkg::t_result r_out;
    logic [4:0]       r_err_base;

    logic             w_out_free;
    logic             w_step;
    nsc_pkg::t_result w_res;

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_step      = r_in_valid && w_out_free;
    assign o_s_tready  = !r_in_valid || w_out_free;
    assign o_cfg_ready = 1'b1;

    // The base may only be rewritten while no request is in flight; this is not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_base <= 5'd0;
        end else if (i_cfg_valid) begin
            r_err_base <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    nsc_core #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_step),
        .i_byte     (r_in_byte),
        .i_err_base (r_err_base),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.error_word, r_out.received_sum, r_out.computed_sum,
                         r_out.body_length, r_out.verdict};

    // An accepted sentence always carries a matching decoded checksum.
    a_ok_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict == nsc_pkg::V_OK) |->
            (r_out.received_sum == r_out.computed_sum))
        else $error("accepted sentence with differing checksums");

    // Overflow is reported on exactly the byte that passes the maximum length.
    a_ovf_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict == nsc_pkg::V_OVERFLOW) |->
            (r_out.body_length == 7'(MAX_LENGTH + 1)))
        else $error("overflow reported at wrong length");

    // A decoded checksum is only reported with a checksum verdict.
    a_rx_sum_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.verdict == nsc_pkg::V_NONE ||
                         r_out.verdict == nsc_pkg::V_OVERFLOW)) |->
            (r_out.received_sum == 8'h00))
        else $error("received checksum reported without checksum verdict");

    // A result appears only after a request was waiting in the input register.
    a_out_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result produced without a pending request");

endmodule

FILE: test/nmea_sentence_checker_tb.sv
// Self-checking testbench for the NMEA sentence checksum checker.
`timescale 1ns / 100ps

module nmea_sentence_checker_tb;

    // The maximum sentence length that the checker is built with.
    localparam int SENTENCE_MAX = 72;
    // Lowercase 'a' is used to build hex digits that the checker must refuse.
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // The ways a generated sentence can end after its body.
    typedef enum int {
        TAIL_GOOD,   // star, correct uppercase digits, CR
        TAIL_WRONG,  // star, well-formed digits of the wrong value, CR
        TAIL_LOWER,  // star, a lowercase hex letter among the digits, CR
        TAIL_JUNK,   // star, two arbitrary bytes, CR
        TAIL_SHORT,  // star, fewer than two digits, CR
        TAIL_EXTRA,  // star, filler bytes, correct digits, CR
        TAIL_NONE    // the sentence is left open
    } t_tail;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;        // [7:0] rx_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;             // [1:0] verdict, [8:2] body_length,
                                        // [16:9] computed_sum, [24:17] received_sum,
                                        // [56:25] error_word, rest zero
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;

    nmea_sentence_checker #(
        .MAX_LENGTH(SENTENCE_MAX)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Bytes waiting to be sent, and the results that accepted bytes must produce.
    logic [7:0]       rx_byte_q[$];
    nsc_pkg::t_result pending_results[$];

    // Our own copy of the sentence state, the error word and the error bit base.
    nsc_pkg::t_phase sen_phase = nsc_pkg::PH_HUNT;
    logic [6:0]  sen_len = '0;
    logic [7:0]  sen_xor = '0;
    logic [15:0] sen_last_two = '0;
    logic [31:0] err_sticky = '0;
    logic [4:0]  err_base = '0;

    int err_count = 0;

    // Pacing controls; the stimulus process changes the modes between phases.
    bit steady_source = 1'b0;
    int sink_mode = 0;
    int burst_left = 1;
    int gap_left = 0;
    int sink_cycle = 0;

    // Bytes of real sentences queued so far; noise between sentences is not counted.
    int sentence_bytes = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // A generous bound on the whole run.
    initial begin
        #20_000_000;
        $display("nmea_sentence_checker_tb: done, errors");
        $finish;
    end

    task automatic report_error(input string msg);
        err_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Returns {is_digit, value} for one checksum character; only 0-9 and A-F count.
    function automatic logic [4:0] decode_hex(input logic [7:0] c);
        if (c >= nsc_pkg::CH_ZERO && c <= nsc_pkg::CH_NINE) begin
            return {1'b1, 4'(c - nsc_pkg::CH_ZERO)};
        end
        if (c >= nsc_pkg::CH_UPPER_A && c <= nsc_pkg::CH_UPPER_F) begin
            return {1'b1, 4'(c - nsc_pkg::CH_UPPER_A + 8'd10)};
        end
        return 5'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? nsc_pkg::CH_ZERO + 8'(n) : nsc_pkg::CH_UPPER_A + 8'(n) - 8'd10;
    endfunction

    // Sets an error flag at the configured base; positions past bit 31 are dropped.
    function automatic void raise_error_flag(input logic [5:0] ofs);
        int pos;
        pos = int'(err_base) + int'(ofs);
        if (pos < 32) begin
            err_sticky[pos] = 1'b1;
        end
    endfunction

    function automatic void clear_sentence_state();
        sen_phase = nsc_pkg::PH_HUNT;
        sen_len = '0;
        sen_xor = '0;
        sen_last_two = '0;
    endfunction

    // Advances our copy of the checker by one received byte and returns the result
    // that the byte must produce.
    function automatic nsc_pkg::t_result next_sentence_result(input logic [7:0] c);
        nsc_pkg::t_result  r;
        nsc_pkg::t_verdict v;
        logic [15:0] prev_two;
        logic [4:0]  hi;
        logic [4:0]  lo;
        logic [7:0]  rcv;
        v = nsc_pkg::V_NONE;
        rcv = '0;
        prev_two = sen_last_two;
        if (sen_phase == nsc_pkg::PH_HUNT) begin
            // While hunting, only a dollar sign matters; it opens a fresh sentence.
            if (c == nsc_pkg::CH_DOLLAR) begin
                clear_sentence_state();
                sen_phase = nsc_pkg::PH_BODY;
            end
        end else begin
            sen_len = sen_len + 7'd1;
            sen_last_two = {sen_last_two[7:0], c};
            if (sen_phase == nsc_pkg::PH_BODY) begin
                // The star is stored but stays out of the checksum.
                if (c == nsc_pkg::CH_STAR) begin
                    sen_phase = nsc_pkg::PH_SUM;
                end else begin
                    sen_xor = sen_xor ^ c;
                end
            end else if (c == nsc_pkg::CH_CR) begin
                // The two bytes stored just before CR are the digits, whatever they are.
                hi = decode_hex(prev_two[15:8]);
                lo = decode_hex(prev_two[7:0]);
                rcv = {hi[3:0], lo[3:0]};
                if (hi[4] && lo[4] && rcv == sen_xor) begin
                    v = nsc_pkg::V_OK;
                end else begin
                    v = nsc_pkg::V_MISMATCH;
                    raise_error_flag(nsc_pkg::ERR_OFS_MISMATCH);
                end
            end
            // A CR on the overflowing byte still gets its checksum verdict.
            if (v == nsc_pkg::V_NONE && sen_len > 7'(SENTENCE_MAX)) begin
                v = nsc_pkg::V_OVERFLOW;
                raise_error_flag(nsc_pkg::ERR_OFS_OVERFLOW);
            end
        end
        r.verdict = v;
        r.body_length = sen_len;
        r.computed_sum = sen_xor;
        r.received_sum = rcv;
        r.error_word = err_sticky;
        if (v != nsc_pkg::V_NONE) begin
            clear_sentence_state();
        end
        return r;
    endfunction

    // Source side: sends queued bytes in bursts of random length with random gaps, none
    // if steady, and predicts each request's result at the edge where it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                pending_results.push_back(next_sentence_result(i_s_tdata));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0 || rx_byte_q.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    i_s_tvalid <= 1'b0;
                end else begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= rx_byte_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = steady_source ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Result side: drives ready on a pattern chosen per phase, and checks every accepted
    // result, field by field, against the oldest prediction.
    always @(posedge i_clk) begin
        nsc_pkg::t_result got;
        nsc_pkg::t_result want;
        sink_cycle++;
        case (sink_mode)
            0: begin
                i_m_tready <= 1'b1;
            end
            1: begin
                i_m_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                i_m_tready <= ((sink_cycle % 7) < 3);
            end
            default: begin
                i_m_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = nsc_pkg::t_result'(o_m_tdata[56:0]);
            if (pending_results.size() == 0) begin
                report_error($sformatf("result with no byte pending: %h", o_m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.verdict != want.verdict) begin
                    report_error($sformatf("verdict %0d, expected %0d",
                                           got.verdict, want.verdict));
                end
                if (got.body_length != want.body_length) begin
                    report_error($sformatf("body_length %0d, expected %0d",
                                           got.body_length, want.body_length));
                end
                if (got.computed_sum != want.computed_sum) begin
                    report_error($sformatf("computed_sum %h, expected %h",
                                           got.computed_sum, want.computed_sum));
                end
                if (got.received_sum != want.received_sum) begin
                    report_error($sformatf("received_sum %h, expected %h",
                                           got.received_sum, want.received_sum));
                end
                if (got.error_word != want.error_word) begin
                    report_error($sformatf("error_word %h, expected %h",
                                           got.error_word, want.error_word));
                end
                if (o_m_tdata[63:57] != '0) begin
                    report_error($sformatf("padding bits set: %h", o_m_tdata[63:57]));
                end
            end
        end
    end

    // Noise for the hunting state: anything but a dollar sign is ignored there.
    task automatic queue_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == nsc_pkg::CH_DOLLAR) begin
                b = ~b;
            end
            rx_byte_q.push_back(b);
        end
    endtask

    // Queues one sentence: dollar, a random body without stars, then the chosen tail.
    task automatic queue_sentence(input int body_len, input t_tail tail);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] d;
        int         n;
        sum = '0;
        n = 1;
        rx_byte_q.push_back(nsc_pkg::CH_DOLLAR);
        for (int i = 0; i < body_len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == nsc_pkg::CH_STAR) begin
                b = nsc_pkg::CH_DOLLAR;
            end
            rx_byte_q.push_back(b);
            sum ^= b;
            n++;
        end
        if (tail != TAIL_NONE) begin
            rx_byte_q.push_back(nsc_pkg::CH_STAR);
            n++;
            case (tail)
                TAIL_GOOD: begin
                    rx_byte_q.push_back(hex_char(sum[7:4]));
                    rx_byte_q.push_back(hex_char(sum[3:0]));
                    n += 2;
                end
                TAIL_WRONG: begin
                    d = sum ^ 8'($urandom_range(1, 255));
                    rx_byte_q.push_back(hex_char(d[7:4]));
                    rx_byte_q.push_back(hex_char(d[3:0]));
                    n += 2;
                end
                TAIL_LOWER: begin
                    // One digit is a lowercase letter, which is not a hex digit here.
                    d = CH_LOWER_A + 8'($urandom_range(0, 5));
                    if ($urandom_range(0, 1) == 0) begin
                        rx_byte_q.push_back(d);
                        rx_byte_q.push_back(hex_char(sum[3:0]));
                    end else begin
                        rx_byte_q.push_back(hex_char(sum[7:4]));
                        rx_byte_q.push_back(d);
                    end
                    n += 2;
                end
                TAIL_JUNK: begin
                    for (int i = 0; i < 2; i++) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == nsc_pkg::CH_CR) begin
                            b = nsc_pkg::CH_NINE;
                        end
                        rx_byte_q.push_back(b);
                        n++;
                    end
                end
                TAIL_SHORT: begin
                    // CR with one or no byte after the star.
                    if ($urandom_range(0, 1) == 0) begin
                        rx_byte_q.push_back(hex_char(sum[3:0]));
                        n++;
                    end
                end
                default: begin
                    for (int i = $urandom_range(1, 5); i > 0; i--) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == nsc_pkg::CH_CR) begin
                            b = nsc_pkg::CH_STAR;
                        end
                        rx_byte_q.push_back(b);
                        n++;
                    end
                    rx_byte_q.push_back(hex_char(sum[7:4]));
                    rx_byte_q.push_back(hex_char(sum[3:0]));
                    n += 2;
                end
            endcase
            rx_byte_q.push_back(nsc_pkg::CH_CR);
            n++;
        end
        sentence_bytes += n;
    endtask

    // Waits until every queued request is accepted and every result has arrived.
    task automatic wait_drained();
        while (rx_byte_q.size() != 0 || i_s_tvalid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes the error bit base; only called while the checker is idle.
    task automatic write_error_base(input logic [4:0] base);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= base;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        err_base = base;
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus: a directed phase, then random phases at several error bit bases.
    initial begin
        logic [4:0] bases[6];
        int         target;
        int         pick;
        bases = '{5'd0, 5'd31, 5'd28, 5'd29, 5'd30, 5'($urandom_range(1, 27))};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_error_base(5'd0);
        // Noise while hunting, including all-zero and all-one bytes.
        rx_byte_q.push_back(8'h00);
        rx_byte_q.push_back(8'hFF);
        rx_byte_q.push_back(nsc_pkg::CH_STAR);
        rx_byte_q.push_back(nsc_pkg::CH_CR);
        // The shortest valid sentence, then a body with a dollar sign inside it.
        queue_sentence(0, TAIL_GOOD);
        rx_byte_q.push_back(nsc_pkg::CH_DOLLAR);
        rx_byte_q.push_back(8'h00);
        rx_byte_q.push_back(nsc_pkg::CH_DOLLAR);
        rx_byte_q.push_back(8'hFF);
        rx_byte_q.push_back(nsc_pkg::CH_STAR);
        rx_byte_q.push_back(hex_char(4'hD));
        rx_byte_q.push_back(hex_char(4'hB));
        rx_byte_q.push_back(nsc_pkg::CH_CR);
        queue_sentence(2, TAIL_WRONG);
        queue_sentence(2, TAIL_LOWER);
        // CR one byte or none after the star, so the star is one of the digits.
        queue_sentence(0, TAIL_SHORT);
        queue_sentence(3, TAIL_SHORT);
        queue_sentence(1, TAIL_JUNK);
        queue_sentence(2, TAIL_EXTRA);
        // CR landing exactly on the byte that passes the maximum length.
        queue_sentence(SENTENCE_MAX - 3, TAIL_GOOD);
        // A body that never ends runs into the length limit.
        queue_sentence(SENTENCE_MAX + 4, TAIL_NONE);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            write_error_base(bases[ph]);
            steady_source = (ph % 3 == 0);
            sink_mode = ph % 4;
            target = sentence_bytes + 200;
            while (sentence_bytes < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    queue_sentence($urandom_range(SENTENCE_MAX + 1, SENTENCE_MAX + 8),
                                   TAIL_NONE);
                end else if (pick < 8) begin
                    queue_sentence($urandom_range(SENTENCE_MAX - 5, SENTENCE_MAX + 2),
                                   TAIL_GOOD);
                end else if (pick < 10) begin
                    // An open sentence whose next dollar sign is just a body byte.
                    queue_sentence($urandom_range(0, 6), TAIL_NONE);
                end else if (pick < 60) begin
                    queue_sentence($urandom_range(0, 12), TAIL_GOOD);
                end else begin
                    queue_sentence($urandom_range(0, 12),
                                   t_tail'(TAIL_WRONG + (pick % 5)));
                end
                if ($urandom_range(0, 3) == 0) begin
                    queue_noise($urandom_range(1, 4));
                end
            end
            wait_drained();
        end

        // Let any stray result show up before the verdict is printed.
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("nmea_sentence_checker_tb: done, clean");
        end else begin
            $display("nmea_sentence_checker_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/nsc_pkg.sv
sv/nsc_core.sv
sv/nmea_sentence_checker.sv
test/nmea_sentence_checker_tb.sv
